### design/thbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the text header/body deframer.
// No dependencies; imported by every module of the block.
package thbd_pkg;

    localparam int BLEN_W  = 31;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] TOK_SAT = 3'd4;
    localparam logic [2:0] TOK_LEN = 3'd2;
    localparam logic [2:0] TOK_MIN = 3'd3;

    typedef enum logic [2:0] {
        PH_START_R,
        PH_START_SP,
        PH_FIRST,
        PH_HEADER,
        PH_BODY
    } t_phase;

    typedef enum logic [3:0] {
        K_TAG,
        K_URI,
        K_LEN,
        K_SEQ,
        K_EXTRA,
        K_KEY,
        K_VALUE,
        K_DELIM,
        K_BODY,
        K_DISCARD
    } t_kind;

    typedef struct packed {
        logic [7:0]        data;
        t_kind             kind;
        logic              last;
        logic [BLEN_W-1:0] blen;
        logic              shrt;
        logic              nocolon;
        logic              err;
    } t_rec;

    typedef struct packed {
        logic two;
        t_rec r0;
        t_rec r1;
    } t_pair;

    function automatic t_rec mk_rec(input logic [7:0] data, input t_kind kind,
                                    input logic last, input logic [BLEN_W-1:0] blen,
                                    input logic shrt, input logic nocolon,
                                    input logic err);
        t_rec r;
        r.data    = data;
        r.kind    = kind;
        r.last    = last;
        r.blen    = blen;
        r.shrt    = shrt;
        r.nocolon = nocolon;
        r.err     = err;
        return r;
    endfunction

endpackage

### design/thbd_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks message framing and tags each byte.
// Emits zero, one or two tagged results per byte. Depends on thbd_pkg.
module thbd_front
    import thbd_pkg::*;
#(
    parameter int LENGTH_BITS = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_room,
    output logic       o_push,
    output t_pair      o_pair
);

    localparam int LB = LENGTH_BITS;

    typedef struct packed {
        logic [2:0]    tok;
        logic [LB-1:0] acc;
        logic          inv;
        logic          crlf;
        logic          colon;
    } t_ln;

    typedef struct packed {
        t_ln   st;
        t_kind kind;
    } t_cres;

    function automatic t_cres content(input t_ln s, input logic [7:0] b,
                                      input logic first);
        t_cres r;
        logic [LB+3:0] v;
        r.st      = s;
        r.st.crlf = 1'b0;
        r.kind    = K_KEY;
        v = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {{LB{1'b0}}, b[3:0]};
        if (first) begin
            if (b == CH_SP) begin
                if (s.tok < TOK_SAT) begin
                    r.st.tok = s.tok + 3'd1;
                end
                r.kind = K_DELIM;
            end else begin
                if (s.tok == TOK_LEN && !s.inv) begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        if (v[LB+3:LB] != 4'd0) begin
                            r.st.inv = 1'b1;
                        end else begin
                            r.st.acc = v[LB-1:0];
                        end
                    end else begin
                        r.st.inv = 1'b1;
                    end
                end
                r.kind = (s.tok < TOK_SAT) ? t_kind'({1'b0, s.tok}) : K_EXTRA;
            end
        end else begin
            if (!s.colon && b == CH_COLON) begin
                r.st.colon = 1'b1;
                r.kind     = K_DELIM;
            end else begin
                r.kind = s.colon ? K_VALUE : K_KEY;
            end
        end
        return r;
    endfunction

    t_phase        r_phase, n_phase;
    t_ln           r_ln, n_ln;
    logic          r_held, n_held;
    logic [LB-1:0] r_rem, n_rem;
    logic          r_err, n_err;

    logic          w_acc;
    logic          w_first;
    logic          w_crlf;
    t_cres         w_c0;
    t_ln           w_mid;
    t_cres         w_c1;
    logic [LB-1:0] w_blen;
    logic [LB-1:0] w_rem_dec;
    logic          w_short;
    logic          w_short_mid;

    assign w_acc     = i_valid && i_room;
    assign w_first   = (r_phase == PH_FIRST);
    assign w_crlf    = r_held && (i_byte == CH_LF);
    assign w_c0      = content(r_ln, CH_CR, w_first);
    assign w_mid     = r_held ? w_c0.st : r_ln;
    assign w_c1      = content(w_mid, i_byte, w_first);
    assign w_blen    = (r_ln.inv || r_ln.tok < TOK_MIN) ? '0 : r_ln.acc;
    assign w_rem_dec = (r_rem != '0) ? r_rem - 1'b1 : r_rem;
    assign w_short   = (r_ln.tok < TOK_MIN);
    assign w_short_mid = (r_phase == PH_HEADER || r_phase == PH_BODY) && (w_mid.tok < TOK_MIN);

    always_comb begin
        n_phase = r_phase;
        n_ln    = r_ln;
        n_held  = r_held;
        n_rem   = r_rem;
        n_err   = r_err;
        if (w_acc && !r_err) begin
            case (r_phase)
                PH_START_R: begin
                    if (i_byte == CH_R) begin
                        n_ln.tok = 3'd0;
                        n_phase  = PH_START_SP;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_START_SP: begin
                    if (i_byte == CH_SP) begin
                        n_ln.tok = 3'd1;
                        n_phase  = PH_FIRST;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_BODY: begin
                    if (w_rem_dec == '0) begin
                        n_phase = PH_START_R;
                        n_ln    = '0;
                        n_held  = 1'b0;
                        n_rem   = '0;
                    end else begin
                        n_rem = w_rem_dec;
                    end
                end
                PH_FIRST, PH_HEADER: begin
                    if (w_crlf) begin
                        n_held = 1'b0;
                        if (w_first) begin
                            n_phase     = PH_HEADER;
                            n_ln.crlf   = 1'b1;
                            n_ln.colon  = 1'b0;
                        end else if (r_ln.crlf) begin
                            if (w_blen == '0) begin
                                n_phase = PH_START_R;
                                n_ln    = '0;
                                n_rem   = '0;
                            end else begin
                                n_phase  = PH_BODY;
                                n_ln.acc = w_blen;
                                n_rem    = w_blen;
                            end
                        end else begin
                            n_ln.crlf  = 1'b1;
                            n_ln.colon = 1'b0;
                        end
                    end else if (i_byte == CH_CR) begin
                        n_ln   = w_mid;
                        n_held = 1'b1;
                    end else begin
                        n_ln   = w_c1.st;
                        n_held = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_START_R;
                    n_ln    = '0;
                    n_held  = 1'b0;
                    n_rem   = '0;
                end
            endcase
        end
    end

    always_comb begin
        o_push        = 1'b0;
        o_pair.two    = 1'b0;
        o_pair.r0     = mk_rec(i_byte, K_DISCARD, 1'b0, '0, 1'b0, 1'b0, 1'b1);
        o_pair.r1     = mk_rec(i_byte, K_DISCARD, 1'b0, '0, 1'b0, 1'b0, 1'b1);
        if (w_acc) begin
            if (r_err) begin
                o_push = 1'b1;
            end else begin
                case (r_phase)
                    PH_START_R: begin
                        o_push = 1'b1;
                        if (i_byte == CH_R) begin
                            o_pair.r0 = mk_rec(i_byte, K_TAG, 1'b0, '0, 1'b0, 1'b0, 1'b0);
                        end
                    end
                    PH_START_SP: begin
                        o_push = 1'b1;
                        if (i_byte == CH_SP) begin
                            o_pair.r0 = mk_rec(i_byte, K_DELIM, 1'b0, '0, 1'b0, 1'b0, 1'b0);
                        end
                    end
                    PH_BODY: begin
                        o_push    = 1'b1;
                        o_pair.r0 = mk_rec(i_byte, K_BODY, (w_rem_dec == '0),
                                           BLEN_W'(r_ln.acc), w_short, 1'b0, 1'b0);
                    end
                    PH_FIRST, PH_HEADER: begin
                        if (w_crlf) begin
                            o_push     = 1'b1;
                            o_pair.two = 1'b1;
                            if (w_first) begin
                                o_pair.r0 = mk_rec(CH_CR, K_DELIM, 1'b0, '0, w_short,
                                                   1'b0, 1'b0);
                                o_pair.r1 = mk_rec(CH_LF, K_DELIM, 1'b0, '0, w_short,
                                                   1'b0, 1'b0);
                            end else if (r_ln.crlf) begin
                                o_pair.r0 = mk_rec(CH_CR, K_DELIM, 1'b0, BLEN_W'(w_blen),
                                                   w_short, 1'b0, 1'b0);
                                o_pair.r1 = mk_rec(CH_LF, K_DELIM, (w_blen == '0),
                                                   BLEN_W'(w_blen), w_short, 1'b0, 1'b0);
                            end else begin
                                o_pair.r0 = mk_rec(CH_CR, K_DELIM, 1'b0, '0, w_short,
                                                   !r_ln.colon, 1'b0);
                                o_pair.r1 = mk_rec(CH_LF, K_DELIM, 1'b0, '0, w_short,
                                                   !r_ln.colon, 1'b0);
                            end
                        end else begin
                            o_push = r_held || (i_byte != CH_CR);
                            if (r_held) begin
                                o_pair.r0  = mk_rec(CH_CR, w_c0.kind, 1'b0, '0, w_short_mid,
                                                    1'b0, 1'b0);
                                o_pair.two = (i_byte != CH_CR);
                                o_pair.r1  = mk_rec(i_byte, w_c1.kind, 1'b0, '0, w_short_mid,
                                                    1'b0, 1'b0);
                            end else begin
                                o_pair.r0  = mk_rec(i_byte, w_c1.kind, 1'b0, '0, w_short_mid,
                                                    1'b0, 1'b0);
                            end
                        end
                    end
                    default: begin
                        o_push    = 1'b1;
                        o_pair.r0 = mk_rec(i_byte, K_DISCARD, 1'b0, '0, 1'b0, 1'b0, 1'b0);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START_R;
            r_ln    <= '0;
            r_held  <= 1'b0;
            r_rem   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ln    <= n_ln;
            r_held  <= n_held;
            r_rem   <= n_rem;
            r_err   <= n_err;
        end
    end

endmodule

### design/thbd_queue.sv
`timescale 1ns / 1ps
// Short queue of result pairs between the front end and the output stage.
// Depends on thbd_pkg.
module thbd_queue
    import thbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_pair,
    input  logic  i_pop,
    output logic  o_room,
    output logic  o_valid,
    output t_pair o_pair
);

    t_pair           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, n_wptr;
    logic [Q_AW-1:0] r_rptr, n_rptr;
    logic [Q_AW:0]   r_count, n_count;
    logic            w_push;
    logic            w_pop;

    assign o_room  = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_pair  = r_mem[r_rptr];
    assign w_push  = i_push && o_room;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wptr  = w_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = w_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + {{Q_AW{1'b0}}, w_push} - {{Q_AW{1'b0}}, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

### design/thbd_back.sv
`timescale 1ns / 1ps
// Output stage: holds one result pair and hands out its results in order.
// Depends on thbd_pkg.
module thbd_back
    import thbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_pair i_q_pair,
    output logic  o_pop,
    input  logic  i_ready,
    output logic  o_valid,
    output t_rec  o_rec
);

    t_pair r_pair;
    logic  r_valid, n_valid;
    logic  r_sel, n_sel;
    logic  w_take;
    logic  w_load;

    assign o_valid = r_valid;
    assign o_rec   = r_sel ? r_pair.r1 : r_pair.r0;
    assign w_take  = r_valid && i_ready;
    assign w_load  = !r_valid || (w_take && (r_sel || !r_pair.two));
    assign o_pop   = w_load && i_q_valid;

    always_comb begin
        n_valid = w_load ? i_q_valid : r_valid;
        n_sel   = w_load ? 1'b0 : (w_take ? 1'b1 : r_sel);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pair <= i_q_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

endmodule

### design/text_header_body_deframer_top.sv
`timescale 1ns / 1ps
// Text header/body deframer, top level.
// Instantiates thbd_front, thbd_queue and thbd_back; depends on thbd_pkg.
//
// Usage: feed received bytes on the s_axis channel, one per transaction.
// Each byte comes back tagged on the m_axis channel: tuser carries the field
// kind, tlast marks the last byte of a complete message, tdata carries the
// byte with the parsed length and status flags. A CR is held until the next
// byte, so a byte may produce zero, one or two output transactions.
// Throughput: one input byte per cycle while m_axis_tready is high and outputs
// are one per byte; a byte that releases a held CR yields two output transactions.
// Path: the results of an accepted byte are written into the four-entry pair
// queue, then loaded into the output register.
// Stall: when m_axis_tready is low the queue fills and s_axis_tready drops
// once it holds four pairs; nothing is lost.
// Reset: i_rst_n, synchronous active low, clears framing state, the sticky
// framing error and the queue; the block then expects "R " to start a message.
module text_header_body_deframer_top
    import thbd_pkg::*;
#(
    parameter int LENGTH_BITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] out_byte, [38:8] body_length,
                                        // [39] first_line_short,
                                        // [40] line_without_colon, [41] framing_error
    output logic [3:0]  m_axis_tuser,   // [3:0] field_kind
    output logic        m_axis_tlast    // message_end
);

    logic  w_room;
    logic  w_push;
    t_pair w_push_pair;
    logic  w_q_valid;
    t_pair w_q_pair;
    logic  w_pop;
    t_rec  w_rec;

    assign s_axis_tready = w_room;

    thbd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_room  (w_room),
        .o_push  (w_push),
        .o_pair  (w_push_pair)
    );

    thbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pair  (w_push_pair),
        .i_pop   (w_pop),
        .o_room  (w_room),
        .o_valid (w_q_valid),
        .o_pair  (w_q_pair)
    );

    thbd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_pair  (w_q_pair),
        .o_pop     (w_pop),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_rec     (w_rec)
    );

    assign m_axis_tdata = {6'b0, w_rec.err, w_rec.nocolon, w_rec.shrt, w_rec.blen, w_rec.data};
    assign m_axis_tuser = w_rec.kind;
    assign m_axis_tlast = w_rec.last;

endmodule
